// File: hdl/rmse_pkg.sv
// ----------------------------------------------------------------------------
// rmse_pkg
// Shared widths, limits and transaction types for the rms error accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package rmse_pkg;

    // set size limit and significant sample bits
    localparam int MAX_ITEMS   = 65536;
    localparam int SAMPLE_BITS = 20;

    // field widths of the transactions
    localparam int SAMPLE_W = 20;
    localparam int RMS_W    = 20;

    // accumulator widths
    localparam int SUM_W  = 58;
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int MAG_W  = SAMPLE_BITS;
    localparam int SQ_W   = 2 * MAG_W;

    // divide and root unit widths
    localparam int ROOT_W = SUM_W / 2;
    localparam int REM_W  = ROOT_W + 3;
    localparam int STEP_W = $clog2(SUM_W);

    // input transaction
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] measured_sample;
        logic signed [SAMPLE_W-1:0] reference_sample;
        logic                       last_of_set;
    } t_in_item;

    // result transaction
    typedef struct packed {
        logic [RMS_W-1:0] rms_error;
        logic             overflow_seen;
    } t_out_item;

    // request into the divide and root unit
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_root_req;

    // response from the divide and root unit
    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_root_rsp;

endpackage

`default_nettype wire

// File: hdl/rmse_root_unit.sv
// ----------------------------------------------------------------------------
// rmse_root_unit
// Floor of sqrt(floor(dividend / divisor)) with one shared trial subtractor:
// a restoring divide, one quotient bit per cycle, then a digit-by-digit
// square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rmse_root_unit
    import rmse_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  t_root_req i_req,
    output t_root_rsp o_rsp
);

    localparam logic [1:0] E_IDLE = 2'd0;
    localparam logic [1:0] E_DIV  = 2'd1;
    localparam logic [1:0] E_SQRT = 2'd2;

    logic [1:0]        r_state;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [SUM_W-1:0]  r_x;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_div;

    logic [REM_W-1:0]  sub_a;
    logic [REM_W-1:0]  sub_b;
    logic [REM_W:0]    sub_diff;
    logic              sub_ge;

    // operand select for the shared subtractor
    always_comb begin
        unique case (r_state)
            E_SQRT: begin
                sub_a = {r_rem[REM_W-3:0], r_x[SUM_W-1 -: 2]};
                sub_b = {1'b0, r_root, 2'b01};
            end
            default: begin
                sub_a = {r_rem[REM_W-2:0], r_x[SUM_W-1]};
                sub_b = {{(REM_W-CNT_W){1'b0}}, r_div};
            end
        endcase
    end

    // shared trial subtract
    assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge   = ~sub_diff[REM_W];

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_done  <= 1'b0;
            r_step  <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                E_IDLE: begin
                    if (i_req.start) begin
                        r_state <= E_DIV;
                        r_step  <= STEP_W'(SUM_W - 1);
                    end
                end
                E_DIV: begin
                    if (r_step == '0) begin
                        r_state <= E_SQRT;
                        r_step  <= STEP_W'(ROOT_W - 1);
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                E_SQRT: begin
                    if (r_step == '0) begin
                        r_state <= E_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                default: begin
                    r_state <= E_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            E_IDLE: begin
                if (i_req.start) begin
                    r_x    <= i_req.dividend;
                    r_div  <= i_req.divisor;
                    r_rem  <= '0;
                    r_root <= '0;
                end
            end
            E_DIV: begin
                // quotient bits shift in behind the dividend bits
                r_x   <= {r_x[SUM_W-2:0], sub_ge};
                r_rem <= sub_ge ? sub_diff[REM_W-1:0] : sub_a;
                if (r_step == '0) begin
                    r_rem <= '0;
                end
            end
            E_SQRT: begin
                r_x    <= {r_x[SUM_W-3:0], 2'b00};
                r_root <= {r_root[ROOT_W-2:0], sub_ge};
                r_rem  <= sub_ge ? sub_diff[REM_W-1:0] : sub_a;
            end
            default: begin
                r_rem <= '0;
            end
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;

endmodule

`default_nettype wire

// File: hdl/rmse_accumulator.sv
// ----------------------------------------------------------------------------
// rmse_accumulator
// Accumulates squared differences of sample pairs and emits the root mean
// square error on the last pair of each set.
// ----------------------------------------------------------------------------
//  channel   valid        stall        payload       direction
//  in        i_in_valid   o_in_stall   i_in_data     sample pair in
//  out       o_out_valid  i_out_stall  o_out_data    rms result out
//
//  A pair that does not end a set passes through capture, multiply and add.
//  A pair that ends a set also runs the divide and root unit, which finds
//  the 58 quotient bits and then the 29 root bits.
//  Synchronous active-low reset clears the sequencer and the accumulators.
//  A stalled result sits in the output register while the next set runs.
// ----------------------------------------------------------------------------
`default_nettype none

module rmse_accumulator
    import rmse_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  wire       i_out_stall,
    output t_out_item o_out_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SQ    = 3'd1;
    localparam logic [2:0] S_ADD   = 3'd2;
    localparam logic [2:0] S_START = 3'd3;
    localparam logic [2:0] S_ROOT  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]       r_state;
    logic [MAG_W-1:0] r_mag;
    logic             r_last;
    logic [SQ_W-1:0]  r_sq;
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ovf;
    logic             r_res_ovf;
    logic [RMS_W-1:0] r_res_root;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             in_acc;
    logic             out_free;
    logic [MAG_W:0]   meas_ext;
    logic [MAG_W:0]   ref_ext;
    logic [MAG_W:0]   diff;
    logic [MAG_W:0]   mag_full;
    logic [SUM_W:0]   sum_ext;
    logic             cnt_full;
    t_root_req        root_req;
    t_root_rsp        root_rsp;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // magnitude of the difference from the significant sample bits
    assign meas_ext = {i_in_data.measured_sample[SAMPLE_BITS-1],
                       i_in_data.measured_sample[SAMPLE_BITS-1:0]};
    assign ref_ext  = {i_in_data.reference_sample[SAMPLE_BITS-1],
                       i_in_data.reference_sample[SAMPLE_BITS-1:0]};
    assign diff     = meas_ext - ref_ext;
    assign mag_full = diff[MAG_W] ? (~diff + 1'b1) : diff;

    // saturating sum and count limit
    assign sum_ext  = {1'b0, r_sum} + (SUM_W + 1)'(r_sq);
    assign cnt_full = (r_cnt == CNT_W'(MAX_ITEMS));

    // divide and root unit
    assign root_req.start    = (r_state == S_START);
    assign root_req.dividend = r_sum;
    assign root_req.divisor  = r_cnt;

    rmse_root_unit u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (root_req),
        .o_rsp   (root_rsp)
    );

    // sequencer and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sum   <= '0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (cnt_full) begin
                        r_ovf <= 1'b1;
                    end else begin
                        if (sum_ext[SUM_W]) begin
                            r_sum <= '1;
                            r_ovf <= 1'b1;
                        end else begin
                            r_sum <= sum_ext[SUM_W-1:0];
                        end
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_state <= r_last ? S_START : S_IDLE;
                end
                S_START: begin
                    // unit takes sum and count at this edge, so the set restarts here
                    r_sum   <= '0;
                    r_cnt   <= '0;
                    r_ovf   <= 1'b0;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (root_rsp.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // item capture, square and result hold
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mag  <= mag_full[MAG_W-1:0];
            r_last <= i_in_data.last_of_set;
        end
        if (r_state == S_SQ) begin
            r_sq <= r_mag * r_mag;
        end
        if (r_state == S_START) begin
            r_res_ovf <= r_ovf;
        end
        if (r_state == S_ROOT && root_rsp.done) begin
            r_res_root <= (|root_rsp.root[ROOT_W-1:RMS_W]) ? '1
                                                           : root_rsp.root[RMS_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out.rms_error     <= r_res_root;
            r_out.overflow_seen <= r_res_ovf;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // count never passes the set limit
    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_ITEMS))
        else $error("pair count above limit");

    // a new result transaction comes only from the result hold state
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_OUT)
        else $error("result raised outside result hold");

    // root unit finishes only while the sequencer waits for it
    a_root_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        root_rsp.done |-> r_state == S_ROOT)
        else $error("root unit done while not waiting");

    // the set restarts as soon as the root unit starts
    a_set_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_START |=> r_cnt == '0 && r_sum == '0 && !r_ovf)
        else $error("accumulators not cleared after last pair");

endmodule

`default_nettype wire

// File: tb/rmse_checker.sv
// ----------------------------------------------------------------------------
// rmse_checker
// Watches both channels of the rms error accumulator. Each accepted sample
// pair updates a local copy of the running sum, count and saturation flag.
// A pair marked last yields one predicted result. Every accepted result is
// compared with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module rmse_checker
    import rmse_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    input  wire       i_in_stall,
    input  t_in_item  i_in_data,
    input  wire       i_out_valid,
    input  wire       i_out_stall,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_result_count,
    output int        o_saturated_sets
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] SUM_CEIL = (64'd1 << SUM_W) - 64'd1;
    localparam logic [63:0] RMS_CEIL = (64'd1 << RMS_W) - 64'd1;

    // running state of the set in progress
    logic [63:0] err_sq_sum    = '0;
    int unsigned pairs_in_set  = 0;
    logic        set_saturated = 1'b0;

    t_out_item rms_expected_q[$];
    int        fails     = 0;
    int        results   = 0;
    int        sat_sets  = 0;

    initial begin
        o_fail_count     = 0;
        o_pending        = 0;
        o_result_count   = 0;
        o_saturated_sets = 0;
    end

    // floor square root, one result bit at a time from the top
    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x)
                root = trial;
        end
        return root;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out_item       want;
        longint signed   meas;
        longint signed   refv;
        logic     [63:0] mag;
        logic     [63:0] sq;
        logic     [63:0] mean;
        logic     [63:0] root;

        if (!i_rst_n) begin
            err_sq_sum    = '0;
            pairs_in_set  = 0;
            set_saturated = 1'b0;
            rms_expected_q.delete();
        end else begin
            // result transaction against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                results++;
                if (rms_expected_q.size() == 0) begin
                    $error("unexpected result: rms_error %0d overflow_seen %0d",
                           i_out_data.rms_error, i_out_data.overflow_seen);
                    fails++;
                end else begin
                    want = rms_expected_q.pop_front();
                    if (i_out_data.rms_error !== want.rms_error) begin
                        $error("rms_error mismatch: expected %0d, actual %0d",
                               want.rms_error, i_out_data.rms_error);
                        fails++;
                    end
                    if (i_out_data.overflow_seen !== want.overflow_seen) begin
                        $error("overflow_seen mismatch: expected %0d, actual %0d",
                               want.overflow_seen, i_out_data.overflow_seen);
                        fails++;
                    end
                end
            end

            // sample pair transaction into the running sum
            if (i_in_valid && !i_in_stall) begin
                meas = longint'($signed(i_in_data.measured_sample));
                refv = longint'($signed(i_in_data.reference_sample));
                if (pairs_in_set >= MAX_ITEMS) begin
                    // set already full, pair dropped
                    set_saturated = 1'b1;
                end else begin
                    mag = (meas >= refv) ? 64'(meas - refv) : 64'(refv - meas);
                    sq  = mag * mag;
                    if (sq > SUM_CEIL - err_sq_sum) begin
                        err_sq_sum    = SUM_CEIL;
                        set_saturated = 1'b1;
                    end else begin
                        err_sq_sum = err_sq_sum + sq;
                    end
                    pairs_in_set++;
                end

                // end of set: floored mean, floored root, then clear
                if (i_in_data.last_of_set) begin
                    mean = (pairs_in_set != 0) ? err_sq_sum / 64'(pairs_in_set) : '0;
                    root = floor_sqrt(mean);
                    if (root > RMS_CEIL)
                        root = RMS_CEIL;
                    want.rms_error     = root[RMS_W-1:0];
                    want.overflow_seen = set_saturated;
                    rms_expected_q.push_back(want);
                    if (set_saturated)
                        sat_sets++;
                    err_sq_sum    = '0;
                    pairs_in_set  = 0;
                    set_saturated = 1'b0;
                end
            end
        end

        o_pending        <= rms_expected_q.size();
        o_fail_count     <= fails;
        o_result_count   <= results;
        o_saturated_sets <= sat_sets;
    end

endmodule

// File: tb/tb_rmse_accumulator.sv
// ----------------------------------------------------------------------------
// tb_rmse_accumulator
// Drives sample pair sets into the rms error accumulator: a directed part
// with extreme and sign-crossing samples, then random sets of mixed length
// under three idle patterns. A checker beside the block predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tb_rmse_accumulator
    import rmse_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3_000_000;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      in_stall;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int pairs_sent    = 0;
    int cycle_count   = 0;

    int fail_count;
    int pending;
    int result_count;
    int saturated_sets;

    rmse_accumulator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    rmse_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_in_data        (in_data),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_out_data       (out_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_result_count   (result_count),
        .o_saturated_sets (saturated_sets)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stalls at random
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one sample pair transaction, with optional idle cycles ahead of it
    task automatic send_pair(input logic signed [SAMPLE_W-1:0] meas,
                             input logic signed [SAMPLE_W-1:0] refv,
                             input logic                       last);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid                 <= 1'b1;
        in_data.measured_sample  <= meas;
        in_data.reference_sample <= refv;
        in_data.last_of_set      <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pairs_sent++;
    endtask

    // mix of extremes, near-zero values and full-range values
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            3, 4:    return SAMPLE_W'($signed($urandom_range(1023)) - 512);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic send_set(input int len);
        logic signed [SAMPLE_W-1:0] meas;
        for (int i = 0; i < len; i++) begin
            meas = pick_sample();
            // some pairs match exactly
            if ($urandom_range(15) == 0)
                send_pair(meas, meas, i == len - 1);
            else
                send_pair(meas, pick_sample(), i == len - 1);
        end
    endtask

    // random sets, mostly short with occasional longer ones
    task automatic random_sets(input int n_pairs);
        int target;
        target = pairs_sent + n_pairs;
        while (pairs_sent < target) begin
            if ($urandom_range(9) == 0)
                send_set($urandom_range(40, 9));
            else
                send_set($urandom_range(6, 1));
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles less than receiver
        send_idle_pct = 24;
        recv_idle_pct <= 49;

        // single pairs at the range extremes and sign crossings
        send_pair(S_MAX, S_MIN, 1'b1);
        send_pair(S_MIN, S_MAX, 1'b1);
        send_pair('0, '0, 1'b1);
        send_pair(S_MAX, S_MAX, 1'b1);
        send_pair(S_MIN, S_MIN, 1'b1);
        // mean below one lsb floors to zero
        send_pair(20'sd1, '0, 1'b0);
        send_pair('0, '0, 1'b1);
        // small mixed set
        send_pair(-20'sd1, 20'sd1, 1'b0);
        send_pair(20'sd256, -20'sd256, 1'b0);
        send_pair(S_MAX, '0, 1'b1);
        // alternating bit patterns and extremes in one set
        send_pair(S_MIN, '0, 1'b0);
        send_pair(S_MAX, S_MIN, 1'b0);
        send_pair('0, S_MIN, 1'b0);
        send_pair(20'sh55555, 20'shAAAAA, 1'b1);

        random_sets(400);

        // receiver idles less than sender
        send_idle_pct = 49;
        recv_idle_pct <= 24;
        random_sets(400);

        // no idling
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        random_sets(400);
        in_valid <= 1'b0;

        // drain outstanding results, then let the block settle
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);

        $display("sent %0d sample pairs in sets of 1 to 40 pairs, checked %0d results",
                 pairs_sent, result_count);
        $display("%0d sets saturated the count, three idle patterns on both channels",
                 saturated_sets);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
hdl/rmse_pkg.sv
hdl/rmse_root_unit.sv
hdl/rmse_accumulator.sv
tb/rmse_checker.sv
tb/tb_rmse_accumulator.sv
